FILE: hdl/tld_pkg.sv
// Package for the teletype line discipline: codes, character constants,
// derived widths and the structs passed between the editor and the emitter.
// No dependencies.
`timescale 1ns / 1ps

package tld_pkg;

    localparam int LINE_SIZE = 128;
    localparam int LS_AW     = $clog2(LINE_SIZE);
    localparam int FILL_W    = $clog2(LINE_SIZE + 1);
    localparam int MAP_DEPTH = 128;

    // request kinds
    localparam logic [2:0] MODE_KEY  = 3'd0;
    localparam logic [2:0] MODE_MAP  = 3'd1;
    localparam logic [2:0] MODE_READ = 3'd2;
    localparam logic [2:0] MODE_REL  = 3'd3;
    localparam logic [2:0] MODE_OUT  = 3'd4;

    // buffer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_READY = 2'd2;

    // config register index
    localparam logic REG_ECHO = 1'b0;

    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_DC1   = 8'h11;
    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_LBR   = 8'h7b;
    localparam logic [7:0] CH_RBR   = 8'h7d;
    localparam logic [7:0] CH_TILDE = 8'h7e;
    localparam logic [7:0] CH_DEL   = 8'h7f;

    // one item's results: n == 0 means a single result without a character
    typedef struct packed {
        logic [2:0][7:0] chars;
        logic [1:0]      n;
        logic            intr;
        logic            refused;
        logic            disc;
        logic [7:0]      len;
        logic [1:0]      bstate;
    } t_desc;

    typedef struct packed {
        t_desc             desc;
        logic              use_map;
        logic              use_ls;
        logic              ls_zero;
        logic              store;
        logic              map_hit;
        logic              byp;
        logic [6:0]        map_addr;
        logic [LS_AW-1:0]  st_addr;
        logic [7:0]        byp_data;
    } t_s1;

endpackage

FILE: hdl/tld_edit.sv
// Editor stage: buffer state, character map and line store memories,
// and the register stage that resolves memory read data into a result set.
// Depends on tld_pkg.
`timescale 1ns / 1ps

module tld_edit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_echo,
    input  logic                 i_vld,
    output logic                 o_rdy,
    input  logic [2:0]           i_mode,
    input  logic [7:0]           i_byte,
    input  logic [6:0]           i_index,
    output logic                 o_vld,
    output tld_pkg::t_desc       o_desc,
    input  logic                 i_take
);

    logic [tld_pkg::FILL_W-1:0]    r_fill, n_fill, fill0;
    logic [1:0]                    r_state, n_state;
    logic                          r_s1_vld;
    tld_pkg::t_s1                  r_s1, n_s1;
    logic [tld_pkg::MAP_DEPTH-1:0] r_map_vld;
    logic [7:0]                    map_mem [tld_pkg::MAP_DEPTH];
    logic [7:0]                    ls_mem  [tld_pkg::LINE_SIZE];
    logic [7:0]                    r_map_rd, r_ls_rd;
    logic [7:0]                    s1_mapped, s1_lsval;
    logic                          accept, in_range;
    logic [tld_pkg::LS_AW-1:0]     rd_addr;

    assign o_rdy    = !r_s1_vld || i_take;
    assign accept   = i_vld && o_rdy;
    assign in_range = 32'(i_index) < tld_pkg::LINE_SIZE;
    assign rd_addr  = tld_pkg::LS_AW'(i_index);
    assign fill0    = (r_state == tld_pkg::ST_IDLE) ? '0 : r_fill;

    always_comb begin
        n_s1          = '0;
        n_fill        = r_fill;
        n_state       = r_state;
        n_s1.map_addr = i_byte[6:0];
        case (i_mode)
            tld_pkg::MODE_KEY: begin
                if (r_state == tld_pkg::ST_READY) begin
                    n_s1.desc.refused = 1'b1;
                end else begin
                    n_fill  = fill0;
                    n_state = tld_pkg::ST_BUSY;
                    if (i_byte == tld_pkg::CH_CR) begin
                        n_state            = tld_pkg::ST_READY;
                        n_s1.desc.intr     = 1'b1;
                        n_s1.desc.chars[0] = tld_pkg::CH_CR;
                        n_s1.desc.chars[1] = tld_pkg::CH_LF;
                        n_s1.desc.n        = 2'd2;
                    end else begin
                        if (i_byte inside {tld_pkg::CH_BS, tld_pkg::CH_DEL}) begin
                            if (fill0 != '0) begin
                                n_fill             = fill0 - tld_pkg::FILL_W'(1);
                                n_s1.desc.chars[0] = tld_pkg::CH_BS;
                                n_s1.desc.chars[1] = tld_pkg::CH_SP;
                                n_s1.desc.chars[2] = tld_pkg::CH_BS;
                                n_s1.desc.n        = 2'd3;
                            end
                        end else if (i_byte == tld_pkg::CH_ESC) begin
                            n_fill             = '0;
                            n_s1.desc.chars[0] = tld_pkg::CH_TILDE;
                            n_s1.desc.chars[1] = tld_pkg::CH_CR;
                            n_s1.desc.chars[2] = tld_pkg::CH_LF;
                            n_s1.desc.n        = 2'd3;
                        end else if (i_byte inside {[tld_pkg::CH_SP:tld_pkg::CH_TILDE]} &&
                                     fill0 < tld_pkg::FILL_W'(tld_pkg::LINE_SIZE)) begin
                            n_s1.store   = 1'b1;
                            n_s1.use_map = 1'b1;
                            n_s1.st_addr = tld_pkg::LS_AW'(fill0);
                            n_fill       = fill0 + tld_pkg::FILL_W'(1);
                            n_s1.desc.n  = 2'd1;
                        end else begin
                            n_s1.desc.chars[0] = tld_pkg::CH_BEL;
                            n_s1.desc.n        = 2'd1;
                        end
                        if (n_fill == '0) begin
                            n_state        = tld_pkg::ST_IDLE;
                            n_s1.desc.intr = 1'b1;
                        end
                    end
                    if (!i_echo) begin
                        n_s1.desc.n = 2'd0;
                    end
                end
            end
            tld_pkg::MODE_MAP: begin
            end
            tld_pkg::MODE_READ: begin
                n_s1.use_ls  = 1'b1;
                n_s1.ls_zero = !in_range;
                n_s1.desc.n  = 2'd1;
            end
            tld_pkg::MODE_REL: begin
                n_state        = tld_pkg::ST_IDLE;
                n_fill         = '0;
                n_s1.desc.intr = 1'b1;
            end
            tld_pkg::MODE_OUT: begin
                n_s1.desc.n = 2'd1;
                case (i_byte)
                    tld_pkg::CH_RBR: begin
                        n_s1.desc.disc = 1'b1;
                        n_s1.desc.n    = 2'd0;
                    end
                    tld_pkg::CH_GT:   n_s1.desc.chars[0] = tld_pkg::CH_DC1;
                    tld_pkg::CH_LT:   n_s1.desc.chars[0] = tld_pkg::CH_DEL;
                    tld_pkg::CH_LBR:  n_s1.desc.chars[0] = tld_pkg::CH_CR;
                    tld_pkg::CH_BANG: n_s1.desc.chars[0] = tld_pkg::CH_LF;
                    default:          n_s1.desc.chars[0] = i_byte;
                endcase
            end
            default: begin
            end
        endcase
        n_s1.desc.len    = 8'(n_fill);
        n_s1.desc.bstate = n_state;
        n_s1.map_hit     = r_map_vld[i_byte[6:0]];
        // store still pending in s1 is written on this same edge
        n_s1.byp         = r_s1_vld && r_s1.store && in_range && (r_s1.st_addr == rd_addr);
        n_s1.byp_data    = s1_mapped;
    end

    // unloaded map entries read as identity
    assign s1_mapped = r_s1.map_hit ? r_map_rd : {1'b0, r_s1.map_addr};
    assign s1_lsval  = r_s1.ls_zero ? 8'd0 : (r_s1.byp ? r_s1.byp_data : r_ls_rd);

    always_comb begin
        o_desc = r_s1.desc;
        if (r_s1.use_map) begin
            o_desc.chars[0] = s1_mapped;
        end else if (r_s1.use_ls) begin
            o_desc.chars[0] = s1_lsval;
        end
    end
    assign o_vld = r_s1_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_state   <= tld_pkg::ST_IDLE;
            r_s1_vld  <= 1'b0;
            r_map_vld <= '0;
        end else begin
            if (accept) begin
                r_fill   <= n_fill;
                r_state  <= n_state;
                r_s1_vld <= 1'b1;
                if (i_mode == tld_pkg::MODE_MAP) begin
                    r_map_vld[i_index] <= 1'b1;
                end
            end else if (i_take) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    // character map: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (accept && i_mode == tld_pkg::MODE_MAP) begin
            map_mem[i_index] <= i_byte;
        end
        if (accept) begin
            r_map_rd <= map_mem[i_byte[6:0]];
        end
    end

    // line store: written when the key leaves s1
    always_ff @(posedge i_clk) begin
        if (r_s1_vld && i_take && r_s1.store) begin
            ls_mem[r_s1.st_addr] <= s1_mapped;
        end
        if (accept) begin
            r_ls_rd <= ls_mem[rd_addr];
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= tld_pkg::FILL_W'(tld_pkg::LINE_SIZE))
        else $error("fill count beyond line size");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tld_pkg::ST_IDLE |-> r_fill == '0)
        else $error("idle buffer holds characters");

    a_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_mode == tld_pkg::MODE_KEY && r_state == tld_pkg::ST_READY
        |=> r_s1.desc.refused && $stable(r_fill) && r_state == tld_pkg::ST_READY)
        else $error("key in read-ready state not refused");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !i_take |=> r_s1_vld && $stable(r_s1))
        else $error("stalled s1 entry changed");

endmodule

FILE: hdl/tld_emit.sv
// Result emitter: holds one item's result set and sends its 1 to 3
// results in order on the output stream. Depends on tld_pkg.
`timescale 1ns / 1ps

module tld_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  tld_pkg::t_desc   i_desc,
    output logic             o_take,
    output logic             o_vld,
    input  logic             i_rdy,
    output logic [7:0]       o_char,
    output logic             o_cvalid,
    output logic             o_last,
    output tld_pkg::t_desc   o_desc
);

    logic            r_vld;
    tld_pkg::t_desc  r_desc;
    logic [1:0]      r_beat;
    logic            last_beat;

    assign last_beat = (r_desc.n == 2'd0) || (r_beat == r_desc.n - 2'd1);
    assign o_take    = !r_vld || (i_rdy && last_beat);
    assign o_vld     = r_vld;
    assign o_last    = last_beat;
    assign o_cvalid  = r_desc.n != 2'd0;
    assign o_char    = o_cvalid ? r_desc.chars[r_beat] : 8'd0;
    assign o_desc    = r_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_beat <= '0;
        end else if (o_take) begin
            r_vld  <= i_vld;
            r_beat <= '0;
        end else if (i_rdy) begin
            r_beat <= r_beat + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_desc <= i_desc;
        end
    end

endmodule

FILE: hdl/teletype_line_discipline.sv
// Teletype line discipline: an item enters on every cycle the output side
// keeps up; the request registers into the editor stage together with the
// character map and line store reads, then passes through one output
// register. An item holds the output until all its results are sent:
// a key gives up to three echo characters, every other request one result.
// The line store and the character map are single-port-write memories
// with registered reads; a map entry never loaded reads as its own index.
// Depends on tld_pkg, tld_edit and tld_emit.
`timescale 1ns / 1ps

module teletype_line_discipline (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [14:8] index, [15] zero
    input  logic [2:0]  s_tuser,   // [2:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_char, [8] out_valid, [9] line_ready,
                                   // [10] interrupt, [18:11] line_length,
                                   // [20:19] buffer_status, [21] refused,
                                   // [22] disconnect_request, [23] zero
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic            r_echo;
    logic            s1_vld, take, cvalid;
    logic [7:0]      out_char;
    tld_pkg::t_desc  s1_desc, em_desc;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == tld_pkg::REG_ECHO) ? {31'd0, r_echo} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo <= 1'b1;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == tld_pkg::REG_ECHO) begin
            r_echo <= pwdata[0];
        end
    end

    tld_edit u_edit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_echo  (r_echo),
        .i_vld   (s_tvalid),
        .o_rdy   (s_tready),
        .i_mode  (s_tuser),
        .i_byte  (s_tdata[7:0]),
        .i_index (s_tdata[14:8]),
        .o_vld   (s1_vld),
        .o_desc  (s1_desc),
        .i_take  (take)
    );

    tld_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (s1_vld),
        .i_desc   (s1_desc),
        .o_take   (take),
        .o_vld    (m_tvalid),
        .i_rdy    (m_tready),
        .o_char   (out_char),
        .o_cvalid (cvalid),
        .o_last   (m_tlast),
        .o_desc   (em_desc)
    );

    assign m_tdata = {1'b0, em_desc.disc, em_desc.refused, em_desc.bstate, em_desc.len,
                      em_desc.intr, em_desc.bstate == tld_pkg::ST_READY, cvalid, out_char};

endmodule

FILE: tb/tb_teletype_line_discipline.sv
// Self-checking testbench for teletype_line_discipline: a line-editor predictor runs
// beside the block over stream and APB stimulus and checks every output word in order.
// Depends on tld_pkg and the teletype_line_discipline RTL.
`timescale 1ns / 1ps

module tb_teletype_line_discipline;
    import tld_pkg::*;

    // modes the block ignores
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int FLOOD_ITEMS  = 40;
    localparam int MAX_SHOWN    = 10;
    localparam int SETTLE       = 8;

    // same layout as m_tdata, lowest field last
    typedef struct packed {
        bit       zero;
        bit       disc;
        bit       refused;
        bit [1:0] bstate;
        bit [7:0] len;
        bit       intr;
        bit       ready;
        bit       valid;
        bit [7:0] ch;
    } t_tty_word;

    typedef struct {
        t_tty_word w;
        bit        last;
    } t_tty_out;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = MODE_KEY;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    bit [7:0]   line_mem [LINE_SIZE];
    bit [7:0]   cmap [MAP_DEPTH];
    bit         line_written [LINE_SIZE];
    int         written_idx [$];
    int         fill;
    logic [1:0] line_state;
    bit         echo_on;

    t_tty_out   tty_out_q [$];
    int         mismatches = 0;
    int         items_sent = 0;
    bit         quiet_sender = 1'b0;
    bit         quiet_receiver = 1'b0;
    bit         hold_req = 1'b0;
    int         hold_left = 0;
    int         stall_left = 0;

    teletype_line_discipline u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 78) return 8'($urandom_range(CH_SP, CH_TILDE));
        if (r < 86) return ($urandom_range(0, 1) != 0) ? CH_BS : CH_DEL;
        if (r < 89) return CH_ESC;
        if ($urandom_range(0, 1) != 0) return 8'($urandom_range(0, 31));
        return 8'($urandom_range(128, 255));
    endfunction

    function automatic logic [7:0] pick_out_byte();
        if ($urandom_range(0, 99) >= 40) return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0:       return CH_GT;
            1:       return CH_LT;
            2:       return CH_LBR;
            3:       return CH_BANG;
            default: return CH_RBR;
        endcase
    endfunction

    // every result of one request carries the status after the request
    function automatic void push_out(bit [7:0] ch, bit valid, bit last, bit intr,
                                     bit refused, bit disc);
        t_tty_out r;
        r.w         = '0;
        r.w.ch      = valid ? ch : 8'h00;
        r.w.valid   = valid;
        r.w.ready   = (line_state == ST_READY);
        r.w.intr    = intr;
        r.w.len     = fill[7:0];
        r.w.bstate  = line_state;
        r.w.refused = refused;
        r.w.disc    = disc;
        r.last      = last;
        tty_out_q.push_back(r);
    endfunction

    function automatic void predict_line_edit(logic [2:0] mode, logic [7:0] b, logic [6:0] idx);
        bit [7:0] echo [3];
        int       n;
        bit       intr;
        bit [7:0] o;
        n    = 0;
        intr = 1'b0;
        case (mode)
            MODE_KEY: begin
                if (line_state != ST_IDLE && line_state != ST_BUSY) begin
                    push_out(8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
                end else begin
                    if (line_state == ST_IDLE) begin
                        line_state = ST_BUSY;
                        fill       = 0;
                    end
                    if (b == CH_CR) begin
                        line_state = ST_READY;
                        intr       = 1'b1;
                        echo[0]    = CH_CR;
                        echo[1]    = CH_LF;
                        n          = 2;
                    end else begin
                        if (b == CH_BS || b == CH_DEL) begin
                            if (fill > 0) begin
                                fill--;
                                echo[0] = CH_BS;
                                echo[1] = CH_SP;
                                echo[2] = CH_BS;
                                n       = 3;
                            end
                        end else if (b == CH_ESC) begin
                            fill    = 0;
                            echo[0] = CH_TILDE;
                            echo[1] = CH_CR;
                            echo[2] = CH_LF;
                            n       = 3;
                        end else if (b >= CH_SP && b <= CH_TILDE && fill < LINE_SIZE) begin
                            line_mem[fill] = cmap[b[6:0]];
                            if (!line_written[fill]) begin
                                line_written[fill] = 1'b1;
                                written_idx.push_back(fill);
                            end
                            echo[0] = cmap[b[6:0]];
                            n       = 1;
                            fill++;
                        end else begin
                            echo[0] = CH_BEL;
                            n       = 1;
                        end
                        // an edit that leaves the line empty drops back to idle
                        if (fill == 0) begin
                            line_state = ST_IDLE;
                            intr       = 1'b1;
                        end
                    end
                    if (!echo_on || n == 0) begin
                        push_out(8'h00, 1'b0, 1'b1, intr, 1'b0, 1'b0);
                    end else begin
                        for (int k = 0; k < n; k++)
                            push_out(echo[k], 1'b1, k == n - 1, intr, 1'b0, 1'b0);
                    end
                end
            end
            MODE_MAP: begin
                cmap[idx] = b;
                push_out(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
            end
            MODE_READ: begin
                push_out(line_mem[idx], 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
            end
            MODE_REL: begin
                line_state = ST_IDLE;
                fill       = 0;
                push_out(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
            end
            MODE_OUT: begin
                if (b == CH_RBR) begin
                    push_out(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
                end else begin
                    o = b;
                    if (b == CH_GT) o = CH_DC1;
                    else if (b == CH_LT) o = CH_DEL;
                    else if (b == CH_LBR) o = CH_CR;
                    else if (b == CH_BANG) o = CH_LF;
                    push_out(o, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
                end
            end
            default: begin
                push_out(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
            end
        endcase
    endfunction

    task automatic send_item(logic [2:0] mode, logic [7:0] b, logic [6:0] idx);
        int gap;
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, idx, b};
        do @(posedge i_clk); while (!s_tready);
        predict_line_edit(mode, b, idx);
        items_sent++;
        gap = pick_gap(quiet_sender);
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic read_written_entry();
        if (written_idx.size() > 0)
            send_item(MODE_READ, 8'($urandom_range(0, 255)),
                      7'(written_idx[$urandom_range(0, written_idx.size() - 1)]));
    endtask

    task automatic drain_outputs();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (tty_out_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_echo(logic [31:0] v);
        drain_outputs();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ECHO, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        echo_on = v[0];
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[0] !== v[0]) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("echo_enable readback: exp %b got %b", v[0], prdata[0]);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_directed_edits();
        send_item(MODE_KEY, 8'h41, 7'h00);
        send_item(MODE_KEY, CH_BS, 7'h7f);      // empties the line
        send_item(MODE_KEY, CH_DEL, 7'h00);     // delete on empty line: no echo
        send_item(MODE_KEY, 8'h00, 7'h00);
        send_item(MODE_KEY, 8'hff, 7'h7f);
        send_item(MODE_KEY, CH_SP, 7'h00);
        send_item(MODE_KEY, CH_TILDE, 7'h00);
        send_item(MODE_KEY, CH_ESC, 7'h00);
        send_item(MODE_KEY, 8'h78, 7'h00);
        send_item(MODE_KEY, 8'h79, 7'h00);
        send_item(MODE_KEY, CH_DEL, 7'h00);
        send_item(MODE_KEY, CH_CR, 7'h00);
        send_item(MODE_KEY, 8'h7a, 7'h00);      // refused while read ready
        send_item(MODE_READ, 8'h00, 7'h00);
        send_item(MODE_REL, 8'h00, 7'h00);
        send_item(MODE_OUT, CH_GT, 7'h00);
        send_item(MODE_OUT, CH_LT, 7'h00);
        send_item(MODE_OUT, CH_LBR, 7'h00);
        send_item(MODE_OUT, CH_BANG, 7'h00);
        send_item(MODE_OUT, CH_RBR, 7'h00);
        send_item(MODE_OUT, 8'hff, 7'h7f);
        send_item(MODE_MAP, 8'h51, 7'h61);
        send_item(MODE_KEY, 8'h61, 7'h00);
        send_item(MODE_MAP, 8'h00, 7'h7e);
        send_item(MODE_KEY, CH_TILDE, 7'h00);
        send_item(MODE_MAP, 8'hff, 7'h7f);
        send_item(MODE_SPARE_LO, 8'hff, 7'h7f);
        send_item(MODE_SPARE_HI, 8'h00, 7'h00);
        send_item(MODE_REL, 8'h00, 7'h00);
    endtask

    task automatic test_echo_off();
        set_echo(32'hffff_fffe);
        send_item(MODE_KEY, 8'h6b, 7'h00);
        send_item(MODE_KEY, CH_BS, 7'h00);
        send_item(MODE_KEY, 8'h01, 7'h00);
        send_item(MODE_KEY, 8'h6d, 7'h00);
        send_item(MODE_KEY, CH_CR, 7'h00);
        send_item(MODE_KEY, 8'h6e, 7'h00);
        send_item(MODE_REL, 8'h00, 7'h00);
        set_echo(32'h0000_0001);
    endtask

    task automatic test_full_line();
        for (int i = 0; i < LINE_SIZE; i++)
            send_item(MODE_KEY, 8'($urandom_range(CH_SP, CH_TILDE)),
                      7'($urandom_range(0, 127)));
        send_item(MODE_KEY, 8'h71, 7'h00);      // no room left: BEL
        send_item(MODE_KEY, CH_BS, 7'h00);
        send_item(MODE_KEY, 8'h71, 7'h00);
        send_item(MODE_READ, 8'h00, 7'h7f);
        send_item(MODE_READ, 8'h00, 7'h40);
        send_item(MODE_KEY, CH_CR, 7'h00);
        send_item(MODE_REL, 8'h00, 7'h00);
    endtask

    task automatic test_output_hold();
        quiet_sender = 1'b1;
        hold_req     = 1'b1;
        for (int i = 0; i < FLOOD_ITEMS; i++)
            send_item(MODE_KEY, pick_key(), 7'($urandom_range(0, 127)));
        send_item(MODE_REL, 8'h00, 7'h00);
        while (hold_req || hold_left > 0) @(posedge i_clk);
        quiet_sender = 1'b0;
    endtask

    task automatic test_random_traffic();
        int       start;
        int       since_cfg;
        int       kind;
        int       n;
        logic [2:0]  mode;
        logic [31:0] v;
        logic [6:0]  idx;
        start     = items_sent;
        since_cfg = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            if (items_sent - since_cfg >= 50) begin
                v    = $urandom;
                v[0] = ($urandom_range(0, 3) != 0);
                set_echo(v);
                since_cfg      = items_sent;
                quiet_sender   = ($urandom_range(0, 3) == 0);
                quiet_receiver = quiet_sender;
            end
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
                repeat (n) send_item(MODE_KEY, pick_key(), 7'($urandom_range(0, 127)));
                send_item(MODE_KEY, CH_CR, 7'($urandom_range(0, 127)));
                repeat ($urandom_range(0, 3)) read_written_entry();
                repeat ($urandom_range(0, 2))
                    send_item(MODE_KEY, pick_key(), 7'($urandom_range(0, 127)));
                repeat ($urandom_range(0, 2))
                    send_item(MODE_OUT, pick_out_byte(), 7'($urandom_range(0, 127)));
                if ($urandom_range(0, 9) != 0)
                    send_item(MODE_REL, 8'($urandom_range(0, 255)),
                              7'($urandom_range(0, 127)));
            end else if (kind < 75) begin
                repeat ($urandom_range(1, 6))
                    send_item(MODE_OUT, pick_out_byte(), 7'($urandom_range(0, 127)));
            end else if (kind < 85) begin
                repeat ($urandom_range(1, 3)) begin
                    idx = 7'($urandom_range(0, 127));
                    case ($urandom_range(0, 2))
                        0:       send_item(MODE_MAP, {1'b0, idx}, idx);
                        1:       send_item(MODE_MAP, 8'($urandom_range(CH_SP, CH_TILDE)), idx);
                        default: send_item(MODE_MAP, 8'($urandom_range(0, 255)), idx);
                    endcase
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    mode = 3'($urandom_range(0, 7));
                    if (mode == MODE_READ)
                        read_written_entry();
                    else
                        send_item(mode, 8'($urandom_range(0, 255)),
                                  7'($urandom_range(0, 127)));
                end
            end
        end
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
    endtask

    // output side: random back-pressure, plus one long hold on request
    always @(negedge i_clk) begin : drive_ready
        int n;
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            n = pick_gap(quiet_receiver);
            if (n > 0) begin
                stall_left = n - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_output
        t_tty_out exp_r;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (tty_out_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected output: got %h last %b", m_tdata, m_tlast);
            end else begin
                exp_r = tty_out_q.pop_front();
                if (m_tdata !== 24'(exp_r.w) || m_tlast !== exp_r.last) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("output mismatch: exp %h last %b, got %h last %b",
                                 24'(exp_r.w), exp_r.last, m_tdata, m_tlast);
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < MAP_DEPTH; i++)
            cmap[i] = i[7:0];
        for (int i = 0; i < LINE_SIZE; i++)
            line_written[i] = 1'b0;
        fill       = 0;
        line_state = ST_IDLE;
        echo_on    = 1'b1;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edits();
        test_echo_off();
        test_full_line();
        test_output_hold();
        test_random_traffic();
        drain_outputs();

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
hdl/tld_pkg.sv
hdl/tld_edit.sv
hdl/tld_emit.sv
hdl/teletype_line_discipline.sv
tb/tb_teletype_line_discipline.sv
